/* hw/rtl/mie_pkg.sv */
package mie_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned NREG = 32;
  localparam int unsigned RIDX = 5;
  localparam logic [XLEN-1:0] RESET_START = 32'h0040_0000;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_SLT  = 6'h2A;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  typedef struct packed {
    logic [1:0]      status;
    logic            gpr_we;
    logic            mul;
    logic [RIDX-1:0] dest;
    logic [XLEN-1:0] value;
    logic [XLEN-1:0] npc;
  } exe_res_t;

endpackage

/* hw/rtl/mie_alu.sv */
module mie_alu (
  input  logic [31:0]            instr,
  input  logic [31:0]            a,
  input  logic [31:0]            b,
  input  logic [31:0]            hi,
  input  logic [31:0]            lo,
  input  logic [31:0]            pc,
  output mie_pkg::exe_res_t      res
);
  import mie_pkg::*;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sa;
  logic [31:0] seq, imm, btgt, jtgt, sum, dif, addi;

  assign op = instr[31:26];
  assign rs = instr[25:21];
  assign rt = instr[20:16];
  assign rd = instr[15:11];
  assign sa = instr[10:6];
  assign fn = instr[5:0];
  assign seq  = pc + 32'd4;
  assign imm  = {{16{instr[15]}}, instr[15:0]};
  assign btgt = seq + {imm[29:0], 2'b00};
  assign jtgt = {seq[31:28], instr[25:0], 2'b00};
  assign sum  = a + b;
  assign dif  = a - b;
  assign addi = a + imm;

  always_comb begin
    res = '0;
    res.npc = seq;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL: begin res.gpr_we = 1'b1; res.dest = rd; res.value = b << sa; end
          FN_SRL: begin
            if (rs[0]) res.status = ST_UNSUP;
            else begin res.gpr_we = 1'b1; res.dest = rd; res.value = b >> sa; end
          end
          FN_JR:   res.npc = a;
          FN_MFHI: begin res.gpr_we = 1'b1; res.dest = rd; res.value = hi; end
          FN_MFLO: begin res.gpr_we = 1'b1; res.dest = rd; res.value = lo; end
          FN_MULT: res.mul = 1'b1;
          FN_ADD: begin
            if ((a[31] ~^ b[31]) && (sum[31] != a[31])) res.status = ST_OVF;
            else begin res.gpr_we = 1'b1; res.dest = rd; res.value = sum; end
          end
          FN_SUB: begin
            if ((a[31] ^ b[31]) && (dif[31] != a[31])) res.status = ST_OVF;
            else begin res.gpr_we = 1'b1; res.dest = rd; res.value = dif; end
          end
          FN_AND: begin res.gpr_we = 1'b1; res.dest = rd; res.value = a & b; end
          FN_OR:  begin res.gpr_we = 1'b1; res.dest = rd; res.value = a | b; end
          FN_XOR: begin res.gpr_we = 1'b1; res.dest = rd; res.value = a ^ b; end
          FN_SLT: begin
            res.gpr_we = 1'b1; res.dest = rd;
            res.value = {31'd0, $signed(a) < $signed(b)};
          end
          default: res.status = ST_UNSUP;
        endcase
      end
      OP_J:   res.npc = jtgt;
      OP_JAL: begin
        res.gpr_we = 1'b1; res.dest = 5'd31; res.value = pc + 32'd8; res.npc = jtgt;
      end
      OP_BEQ:  if (a == b) res.npc = btgt;
      OP_BNE:  if (a != b) res.npc = btgt;
      OP_BLEZ: if (!($signed(a) > 0)) res.npc = btgt;
      OP_BGTZ: if ($signed(a) > 0) res.npc = btgt;
      OP_ADDI: begin
        if ((a[31] ~^ imm[31]) && (addi[31] != a[31])) res.status = ST_OVF;
        else begin res.gpr_we = 1'b1; res.dest = rt; res.value = addi; end
      end
      OP_LUI: begin res.gpr_we = 1'b1; res.dest = rt; res.value = {instr[15:0], 16'd0}; end
      default: res.status = ST_UNSUP;
    endcase
    if (res.gpr_we && (res.dest == '0)) begin
      res.gpr_we = 1'b0;
      res.value = '0;
    end
  end
endmodule

/* hw/rtl/mips_integer_execute_core.sv */
// A result beat is presented in the cycle after its input beat is accepted.
// Throughput: one instruction per cycle unless stalled by out_ready or cfg_valid;
// the register file, HI/LO and PC are updated at the edge the beat is taken, so the
// next beat sees them. Reset (synchronous, rst_n low): all registers, HI, LO
// cleared, PC set to 0x00400000, result stage emptied.
module mips_integer_execute_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_reg_written,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic [31:0] out_next_pc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_start_address
);
  import mie_pkg::*;

  // Architectural state. Register zero is never written so it reads as zero.
  logic [31:0] gpr_r [NREG];
  logic [31:0] hi_r, lo_r, pc_r;
  logic [63:0] prod;
  exe_res_t    res;
  logic        take;

  // The result register is single entry; a new beat is taken whenever it is
  // empty or being drained in the same cycle. A start address write takes
  // the PC in that cycle, so no instruction beat is taken alongside it.
  assign in_ready  = (!out_valid || out_ready) && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;

  // The execute stage reads the register file directly; the input side
  // register is the architectural state itself.
  mie_alu u_alu (
    .instr (in_instr_word),
    .a     (gpr_r[in_instr_word[25:21]]),
    .b     (gpr_r[in_instr_word[20:16]]),
    .hi    (hi_r),
    .lo    (lo_r),
    .pc    (pc_r),
    .res   (res)
  );

  assign prod = $signed(gpr_r[in_instr_word[25:21]]) * $signed(gpr_r[in_instr_word[20:16]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) gpr_r[i] <= '0;
      hi_r <= '0;
      lo_r <= '0;
      pc_r <= RESET_START;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pc_r    <= cfg_start_address;
      end
      if (take) begin
        pc_r <= res.npc;
        if (res.gpr_we) gpr_r[res.dest] <= res.value;
        if (res.mul) begin
          hi_r <= prod[63:32];
          lo_r <= prod[31:0];
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; MULT reports the low word as the written value.
  always_ff @(posedge clk) begin
    if (take) begin
      out_status      <= res.status;
      out_reg_written <= res.gpr_we || res.mul;
      out_dest_index  <= res.mul ? 5'd0 : res.dest;
      out_dest_value  <= res.mul ? prod[31:0] : res.value;
      out_next_pc     <= res.npc;
    end
  end
endmodule

/* hw/rtl/mie_checker.sv */
module mie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_reg_written,
  input logic [4:0]  out_dest_index,
  input logic [31:0] out_dest_value
);
  import mie_pkg::*;

  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("beat lost");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("overrun");
  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_written |-> out_dest_value == 32'd0 && out_dest_index == 5'd0)
    else $error("stale write fields");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> !out_reg_written) else $error("write on fault");
endmodule

bind mips_integer_execute_core mie_checker u_chk (.*);
